>>> rtl/pra_pkg.sv
package pra_pkg;

  localparam int MaxHolders = 16;
  localparam int SlotBits = $clog2(MaxHolders);
  localparam int AmtBits = 32;

  typedef logic [SlotBits-1:0] slot_t;
  typedef logic [AmtBits-1:0] amt_t;

  typedef enum logic [2:0] {
    ACT_ACQUIRE = 3'd0,
    ACT_PREEMPT = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_DROP    = 3'd3,
    ACT_REPRIO  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_PARTIAL  = 3'd1,
    ST_NOT_HOLD = 3'd2,
    ST_EXCEEDS  = 3'd3,
    ST_FULL     = 3'd4,
    ST_BAD_AMT  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]        owner;
    logic signed [15:0] prio;
    amt_t              amount;
    logic [31:0]       stamp;
  } entry_t;

  typedef struct packed {
    logic   we;
    slot_t  waddr;
    entry_t wdata;
    slot_t  raddr;
  } mem_req_t;

endpackage

>>> rtl/pra_table.sv
module pra_table (
  input  logic              clk,
  input  pra_pkg::mem_req_t req,
  output pra_pkg::entry_t   rdata
);

  pra_pkg::entry_t mem [pra_pkg::MaxHolders];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> rtl/pra_ctrl.sv
module pra_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [31:0]             cfg_data,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              action,
  input  logic [7:0]              holder_id,
  input  logic signed [15:0]      priority_req,
  input  logic [31:0]             amount,
  output pra_pkg::mem_req_t       mreq,
  input  pra_pkg::entry_t         rdata,
  output logic                    done,
  output logic                    kind,
  output logic [7:0]              victim_id,
  output logic [31:0]             victim_amount,
  output logic [31:0]             granted,
  output logic [31:0]             remaining,
  output logic [2:0]              status,
  output logic [31:0]             held_now,
  output logic [31:0]             in_use_now,
  output logic                    last
);

  typedef enum logic [2:0] {S_IDLE, S_FIND, S_DECIDE, S_VSCAN, S_VTAKE, S_FIN} state_t;

  localparam int CntBits = pra_pkg::SlotBits + 1;

  state_t state;
  logic [pra_pkg::MaxHolders-1:0] valid;
  pra_pkg::amt_t capacity, in_use, rem, gr;
  logic [31:0] stamp_ctr;
  logic [2:0] act;
  logic [7:0] id;
  logic signed [15:0] pri;
  pra_pkg::amt_t amt;
  logic [CntBits-1:0] cnt;
  logic rd_ok;
  pra_pkg::slot_t rd_slot;
  logic have_slot, have_free, have_v;
  pra_pkg::slot_t slot, fslot, vslot;
  pra_pkg::entry_t self_e, v_e;
  logic mem_we;
  pra_pkg::slot_t mem_waddr;
  pra_pkg::entry_t mem_wdata;

  pra_pkg::amt_t avail, take, sum_held;
  logic better;

  always_comb begin
    avail = (capacity > in_use) ? capacity - in_use : '0;
    take = (avail < amt) ? avail : amt;
    better = !have_v || (rdata.prio < v_e.prio) ||
             (rdata.prio == v_e.prio && rdata.stamp > v_e.stamp);
    sum_held = self_e.amount;
  end

  assign busy = (state != S_IDLE);
  assign mreq = '{we: mem_we, waddr: mem_waddr, wdata: mem_wdata,
                  raddr: cnt[pra_pkg::SlotBits-1:0]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    mem_we <= 1'b0;
    if (cfg_we) begin
      capacity <= cfg_data;
    end
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      capacity <= 32'd1;
      in_use <= '0;
      stamp_ctr <= '0;
      cnt <= '0;
      rd_ok <= 1'b0;
      mem_we <= 1'b0;
      done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          rd_ok <= 1'b0;
          if (start && action <= 3'(pra_pkg::ACT_REPRIO)) begin
            act <= action;
            id <= holder_id;
            pri <= priority_req;
            amt <= amount;
            have_slot <= 1'b0;
            have_free <= 1'b0;
            state <= S_FIND;
          end
        end
        S_FIND: begin
          rd_ok <= (cnt < CntBits'(pra_pkg::MaxHolders));
          rd_slot <= cnt[pra_pkg::SlotBits-1:0];
          if (cnt < CntBits'(pra_pkg::MaxHolders)) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_ok) begin
            if (valid[rd_slot] && rdata.owner == id && !have_slot) begin
              have_slot <= 1'b1;
              slot <= rd_slot;
              self_e <= rdata;
            end
            if (!valid[rd_slot] && !have_free) begin
              have_free <= 1'b1;
              fslot <= rd_slot;
            end
          end
          if (rd_ok && rd_slot == pra_pkg::slot_t'(pra_pkg::MaxHolders - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          done <= 1'b1;
          kind <= 1'b1;
          victim_id <= '0;
          victim_amount <= '0;
          granted <= '0;
          remaining <= '0;
          last <= 1'b1;
          in_use_now <= in_use;
          held_now <= have_slot ? self_e.amount : '0;
          state <= S_IDLE;
          if (act <= 3'(pra_pkg::ACT_PREEMPT)) begin
            remaining <= amt;
            if (amt == '0 || amt > capacity) begin
              status <= pra_pkg::ST_BAD_AMT;
            end else if (!have_slot && !have_free) begin
              status <= pra_pkg::ST_FULL;
              held_now <= '0;
            end else begin
              done <= 1'b0;
              gr <= take;
              rem <= amt - take;
              in_use <= in_use + take;
              if (take != '0) begin
                if (!have_slot) begin
                  self_e <= '{owner: id, prio: pri, amount: take, stamp: stamp_ctr};
                  stamp_ctr <= stamp_ctr + 1'b1;
                  have_slot <= 1'b1;
                  slot <= fslot;
                  valid[fslot] <= 1'b1;
                  mem_waddr <= fslot;
                  mem_wdata <= '{owner: id, prio: pri, amount: take, stamp: stamp_ctr};
                end else begin
                  self_e.amount <= self_e.amount + take;
                  mem_waddr <= slot;
                  mem_wdata <= '{owner: self_e.owner, prio: self_e.prio,
                                 amount: self_e.amount + take, stamp: self_e.stamp};
                end
                mem_we <= 1'b1;
              end
              cnt <= '0;
              rd_ok <= 1'b0;
              have_v <= 1'b0;
              state <= (act == 3'(pra_pkg::ACT_PREEMPT) && amt != take) ? S_VSCAN : S_FIN;
            end
          end else if (act == 3'(pra_pkg::ACT_RELEASE)) begin
            if (amt == '0) begin
              status <= pra_pkg::ST_BAD_AMT;
            end else if (!have_slot) begin
              status <= pra_pkg::ST_NOT_HOLD;
            end else if (amt > self_e.amount) begin
              status <= pra_pkg::ST_EXCEEDS;
            end else begin
              status <= pra_pkg::ST_DONE;
              held_now <= self_e.amount - amt;
              in_use <= (in_use >= amt) ? in_use - amt : '0;
              in_use_now <= (in_use >= amt) ? in_use - amt : '0;
              if (self_e.amount == amt) begin
                valid[slot] <= 1'b0;
              end
              mem_we <= 1'b1;
              mem_waddr <= slot;
              mem_wdata <= '{owner: self_e.owner, prio: self_e.prio,
                             amount: self_e.amount - amt, stamp: self_e.stamp};
            end
          end else if (!have_slot) begin
            status <= pra_pkg::ST_NOT_HOLD;
          end else if (act == 3'(pra_pkg::ACT_DROP)) begin
            status <= pra_pkg::ST_DONE;
            held_now <= '0;
            valid[slot] <= 1'b0;
            in_use <= (in_use >= self_e.amount) ? in_use - self_e.amount : '0;
            in_use_now <= (in_use >= self_e.amount) ? in_use - self_e.amount : '0;
          end else begin
            status <= pra_pkg::ST_DONE;
            mem_we <= 1'b1;
            mem_waddr <= slot;
            mem_wdata <= '{owner: self_e.owner, prio: pri,
                           amount: self_e.amount, stamp: self_e.stamp};
          end
        end
        S_VSCAN: begin
          rd_ok <= (cnt < CntBits'(pra_pkg::MaxHolders));
          rd_slot <= cnt[pra_pkg::SlotBits-1:0];
          if (cnt < CntBits'(pra_pkg::MaxHolders)) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_ok) begin
            if (valid[rd_slot] && !(have_slot && rd_slot == slot) && rdata.prio < pri
                && better) begin
              have_v <= 1'b1;
              vslot <= rd_slot;
              v_e <= rdata;
            end
            if (rd_slot == pra_pkg::slot_t'(pra_pkg::MaxHolders - 1)) begin
              state <= S_VTAKE;
            end
          end
        end
        S_VTAKE: begin
          cnt <= '0;
          rd_ok <= 1'b0;
          have_v <= 1'b0;
          if (!have_v) begin
            state <= S_FIN;
          end else begin
            done <= 1'b1;
            kind <= 1'b0;
            victim_id <= v_e.owner;
            victim_amount <= v_e.amount;
            granted <= '0;
            remaining <= '0;
            status <= pra_pkg::ST_DONE;
            held_now <= '0;
            in_use_now <= in_use;
            last <= 1'b0;
            valid[vslot] <= 1'b0;
            state <= (v_e.amount < rem) ? S_VSCAN : S_FIN;
            if (v_e.amount >= rem || v_e.amount != '0) begin
              if (!have_slot) begin
                have_slot <= 1'b1;
                slot <= vslot;
                valid[vslot] <= 1'b1;
                stamp_ctr <= stamp_ctr + 1'b1;
                self_e <= '{owner: id, prio: pri,
                            amount: (v_e.amount < rem) ? v_e.amount : rem,
                            stamp: stamp_ctr};
                mem_waddr <= vslot;
                mem_wdata <= '{owner: id, prio: pri,
                               amount: (v_e.amount < rem) ? v_e.amount : rem,
                               stamp: stamp_ctr};
              end else begin
                self_e.amount <= sum_held + ((v_e.amount < rem) ? v_e.amount : rem);
                mem_waddr <= slot;
                mem_wdata <= '{owner: self_e.owner, prio: self_e.prio,
                               amount: sum_held + ((v_e.amount < rem) ? v_e.amount : rem),
                               stamp: self_e.stamp};
              end
              mem_we <= 1'b1;
            end
            if (v_e.amount < rem) begin
              rem <= rem - v_e.amount;
              gr <= gr + v_e.amount;
            end else begin
              in_use <= (in_use >= v_e.amount - rem) ? in_use - (v_e.amount - rem) : '0;
              gr <= gr + rem;
              rem <= '0;
            end
          end
        end
        S_FIN: begin
          done <= 1'b1;
          kind <= 1'b1;
          victim_id <= '0;
          victim_amount <= '0;
          granted <= gr;
          remaining <= rem;
          status <= (rem != '0) ? pra_pkg::ST_PARTIAL : pra_pkg::ST_DONE;
          held_now <= have_slot ? self_e.amount : '0;
          in_use_now <= in_use;
          last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/preemptive_resource_allocator_top.sv
// Commands are taken while busy is low. Every command first makes one pass
// over the holder table and then decides, so a release, drop or reprioritize
// keeps busy high through the scan and the decision, and an acquire or preempt
// that passes its checks adds a final step. A preempt still short of units
// adds a further scan for each victim it takes, and one more when no further
// victim is found. All of this is set by the single read port of the holder
// table. Results appear for one cycle with done high and cannot be stalled;
// the completion carries last and arrives in the cycle in which busy falls.
module preemptive_resource_allocator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [7:0]         holder_id,
  input  logic signed [15:0] priority_req,
  input  logic [31:0]        amount,
  output logic               done,
  output logic               kind,
  output logic [7:0]         victim_id,
  output logic [31:0]        victim_amount,
  output logic [31:0]        granted,
  output logic [31:0]        remaining,
  output logic [2:0]         status,
  output logic [31:0]        held_now,
  output logic [31:0]        in_use_now,
  output logic               last
);

  pra_pkg::mem_req_t mreq;
  pra_pkg::entry_t   rdata;

  pra_table u_table (.clk(clk), .req(mreq), .rdata(rdata));

  pra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .action(action), .holder_id(holder_id),
    .priority_req(priority_req), .amount(amount), .mreq(mreq), .rdata(rdata),
    .done(done), .kind(kind), .victim_id(victim_id), .victim_amount(victim_amount),
    .granted(granted), .remaining(remaining), .status(status), .held_now(held_now),
    .in_use_now(in_use_now), .last(last)
  );

endmodule

>>> rtl/pra_checker.sv
module pra_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic kind,
  input logic last
);

  a_last_kind: assert property (@(posedge clk) disable iff (rst) done |-> (last == kind))
    else $error("last and kind disagree");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(busy)) |-> !done)
    else $error("result while idle");
  a_end_frees: assert property (@(posedge clk) disable iff (rst) (done && last) |-> !busy)
    else $error("busy after completion");
  a_victim_busy: assert property (@(posedge clk) disable iff (rst) (done && !kind) |-> busy)
    else $error("victim notice while idle");

endmodule

bind preemptive_resource_allocator_top pra_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .kind(kind), .last(last)
);
